>>> src/mphc_pkg.sv
package mphc_pkg;

    // Number of heater channels and the width of a channel index.
    localparam int CH_N = 6;
    localparam int CH_W = 3;

    // Targets at or below this raw Q8.8 value (0.1 degrees) switch the outputs off.
    localparam logic signed [15:0] LOW_TARGET = 16'sd25;

    // Saturation bounds of the Q24.24 integral.
    localparam logic signed [47:0] ISAT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ISAT_MIN = 48'sh8000_0000_0000;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MAX_PWM = 3'd0;
    localparam logic [2:0] CFG_MIN_PWM = 3'd1;
    localparam logic [2:0] CFG_SAFETY  = 3'd2;
    localparam logic [2:0] CFG_PERIOD  = 3'd3;
    localparam logic [2:0] CFG_MASK    = 3'd4;

    // Command opcodes.
    localparam logic [2:0] OP_SAMPLE = 3'd0;
    localparam logic [2:0] OP_TICK   = 3'd1;
    localparam logic [2:0] OP_TARGET = 3'd2;
    localparam logic [2:0] OP_ESTOP  = 3'd3;
    localparam logic [2:0] OP_GAINS  = 3'd4;

    // Status codes of result items.
    localparam logic [3:0] ST_PWM         = 4'd0;
    localparam logic [3:0] ST_DONE        = 4'd1;
    localparam logic [3:0] ST_INACTIVE    = 4'd2;
    localparam logic [3:0] ST_INVALID     = 4'd3;
    localparam logic [3:0] ST_OVERHEAT    = 4'd4;
    localparam logic [3:0] ST_ZERO_TARGET = 4'd5;
    localparam logic [3:0] ST_TARGET_IGN  = 4'd6;
    localparam logic [3:0] ST_STOP_ON     = 4'd7;
    localparam logic [3:0] ST_STOP_ALRDY  = 4'd8;
    localparam logic [3:0] ST_STILL_HOT   = 4'd9;
    localparam logic [3:0] ST_ALRDY_REL   = 4'd10;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [3:0]  channel;
        logic signed [15:0] sample_value;
        logic [23:0]        kp_gain;
        logic [23:0]        ki_gain;
        logic               activate;
    } t_in_item;

    typedef struct packed {
        logic [3:0] status;
        logic [2:0] out_channel;
        logic [7:0] pwm;
        logic       emergency;
        logic       last;
    } t_out_item;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_ERR,
        DP_WAIT,
        DP_CLAMP,
        DP_MUL1,
        DP_MUL2,
        DP_SUM1,
        DP_SUM2,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op          op;
        logic [CH_W-1:0] k;
        logic            wr_temp;
        logic            wr_target;
        logic            gain_one;
        logic            gain_all;
        logic            set_estop;
        logic            clr_estop;
        logic            set_safe;
        logic            clr_safe;
        logic            zero_pwm;
        logic            clr_integ;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0]        opcode;
        logic signed [3:0] channel;
        logic              activate;
        logic              val_hot;
        logic              val_low;
        logic              target_low;
        logic              rel_hot;
        logic              estop;
        logic              safe;
        logic [CH_N-1:0]   mask;
        logic              div_busy;
        logic [7:0]        pwm_sel;
    } t_dp_stat;

endpackage

>>> src/multichannel_pi_heater_control.sv
// A command is loaded and decoded, then its result items follow one per cycle unless the output stalls.
// The block takes one item at a time; a control tick runs the PI law on each active channel,
// waiting for the 48-step windup-limit divider on each one.
// Reset is synchronous and active low; it restores the register defaults, the target,
// gains, integrals, PWM values and flags at once, with no clearing pass.
module multichannel_pi_heater_control import mphc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    // The controller sequences each command: it decodes the item, for a
    // tick steps the datapath through the PI law channel by channel, and
    // then publishes any PWM items and the closing status item through its
    // output register. The output register lets the next item be accepted
    // while the status item still waits to be taken.
    t_dp_cmd  cmd;
    t_dp_stat stat;

    mphc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The datapath holds the configuration, the per-channel state and the
    // fixed-point arithmetic, including the shared divider for the
    // anti-windup limits.
    mphc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_item),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

endmodule

>>> src/mphc_div.sv
module mphc_div import mphc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_ki,
    input  logic [7:0]  i_max,
    input  logic [7:0]  i_min,
    output logic        o_busy,
    output logic [47:0] o_up,
    output logic [47:0] o_dn
);

    // Two restoring division lanes share one divisor: max*2^40/ki and min*2^40/ki,
    // one quotient bit per cycle.
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [23:0] r_d;
    logic [47:0] r_na, r_nb, r_qa, r_qb;
    logic [23:0] r_ra, r_rb;
    logic [24:0] ta, tb;
    logic        ga, gb;

    assign ta = {r_ra, r_na[47]};
    assign tb = {r_rb, r_nb[47]};
    assign ga = ta >= {1'b0, r_d};
    assign gb = tb >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd47) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d  <= i_ki;
            r_na <= {i_max, 40'b0};
            r_nb <= {i_min, 40'b0};
            r_ra <= '0;
            r_rb <= '0;
            r_qa <= '0;
            r_qb <= '0;
        end else if (r_busy) begin
            r_na <= {r_na[46:0], 1'b0};
            r_nb <= {r_nb[46:0], 1'b0};
            r_ra <= ga ? 24'(ta - {1'b0, r_d}) : ta[23:0];
            r_rb <= gb ? 24'(tb - {1'b0, r_d}) : tb[23:0];
            r_qa <= {r_qa[46:0], ga};
            r_qb <= {r_qb[46:0], gb};
        end
    end

    assign o_busy = r_busy;
    assign o_up   = r_qa[47] ? ISAT_MAX : r_qa;
    assign o_dn   = r_qb[47] ? ISAT_MAX : r_qb;

endmodule

>>> src/mphc_dp.sv
module mphc_dp import mphc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  t_in_item    i_item,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat
);

    logic [7:0]         r_max, r_min;
    logic signed [15:0] r_thr;
    logic [15:0]        r_period;
    logic [CH_N-1:0]    r_mask;
    logic signed [15:0] r_target;
    logic signed [15:0] r_temp [CH_N];
    logic signed [47:0] r_integ [CH_N];
    logic [23:0]        r_kp [CH_N];
    logic [23:0]        r_ki [CH_N];
    logic [7:0]         r_pwm [CH_N];
    logic               r_estop, r_safe;

    t_in_item           r_item;
    logic signed [16:0] r_err;
    logic signed [33:0] r_eprod;
    logic signed [47:0] r_acc;
    logic signed [41:0] r_prop;
    logic [47:0]        r_plo, r_phi;
    logic [59:0]        r_ip;
    logic signed [59:0] r_tot;

    logic [CH_W-1:0]    ich;
    logic [23:0]        ki_k, kp_k;
    logic               kiz;
    logic               div_busy;
    logic [47:0]        up, dn;
    logic signed [48:0] sum49;
    logic signed [47:0] sat, cl1, cl2;
    logic signed [59:0] hi, lo, t1, t2;
    logic               rel_hot;

    assign ich  = r_item.channel[CH_W-1:0];
    assign ki_k = r_ki[i_cmd.k];
    assign kp_k = r_kp[i_cmd.k];
    assign kiz  = (ki_k == 24'd0);

    mphc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == DP_ERR),
        .i_ki    (ki_k),
        .i_max   (r_max),
        .i_min   (r_min),
        .o_busy  (div_busy),
        .o_up    (up),
        .o_dn    (dn)
    );

    // Integral update with saturation, then the anti-windup limits.
    always_comb begin
        sum49 = $signed({r_integ[i_cmd.k][47], r_integ[i_cmd.k]})
              + $signed({{15{r_eprod[33]}}, r_eprod});
        if (sum49[48] != sum49[47]) begin
            sat = sum49[48] ? ISAT_MIN : ISAT_MAX;
        end else begin
            sat = sum49[47:0];
        end
        cl1 = (r_acc > $signed(up)) ? $signed(up) : r_acc;
        cl2 = (cl1 < $signed(dn)) ? $signed(dn) : cl1;
    end

    // Output clamp at scale 2^-40.
    always_comb begin
        hi = $signed({12'b0, r_max, 40'b0});
        lo = $signed({12'b0, r_min, 40'b0});
        t1 = (r_tot > hi) ? hi : r_tot;
        t2 = (t1 < lo) ? lo : t1;
    end

    always_comb begin
        rel_hot = 1'b0;
        for (int k = 0; k < CH_N; k++) begin
            if (r_mask[k] && (r_temp[k] >= r_thr)) begin
                rel_hot = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= 8'd60;
            r_min    <= 8'd0;
            r_thr    <= 16'sd20480;
            r_period <= 16'd262;
            r_mask   <= 6'd48;
            r_target <= 16'sd12800;
            r_estop  <= 1'b0;
            r_safe   <= 1'b1;
            for (int k = 0; k < CH_N; k++) begin
                r_temp[k]  <= '0;
                r_integ[k] <= '0;
                r_kp[k]    <= 24'd131072;
                r_ki[k]    <= 24'd3277;
                r_pwm[k]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_PWM: r_max    <= i_cfg_data[7:0];
                    CFG_MIN_PWM: r_min    <= i_cfg_data[7:0];
                    CFG_SAFETY:  r_thr    <= $signed(i_cfg_data);
                    CFG_PERIOD:  r_period <= i_cfg_data;
                    CFG_MASK:    r_mask   <= i_cfg_data[CH_N-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.wr_temp) begin
                r_temp[ich] <= r_item.sample_value;
            end
            if (i_cmd.wr_target) begin
                r_target <= r_item.sample_value;
            end
            if (i_cmd.gain_one) begin
                r_kp[ich] <= r_item.kp_gain;
                r_ki[ich] <= r_item.ki_gain;
            end
            for (int k = 0; k < CH_N; k++) begin
                if (i_cmd.gain_all && r_mask[k]) begin
                    r_kp[k] <= r_item.kp_gain;
                    r_ki[k] <= r_item.ki_gain;
                end
                if (i_cmd.zero_pwm) begin
                    r_pwm[k] <= '0;
                end
                if (i_cmd.clr_integ) begin
                    r_integ[k] <= '0;
                end
            end
            if (i_cmd.set_estop) begin
                r_estop <= 1'b1;
            end
            if (i_cmd.clr_estop) begin
                r_estop <= 1'b0;
            end
            if (i_cmd.set_safe) begin
                r_safe <= 1'b1;
            end
            if (i_cmd.clr_safe) begin
                r_safe <= 1'b0;
            end
            if (i_cmd.op == DP_CLAMP && !kiz) begin
                r_integ[i_cmd.k] <= cl2;
            end
            if (i_cmd.op == DP_CLAMP && kiz) begin
                r_integ[i_cmd.k] <= r_acc;
            end
            if (i_cmd.op == DP_OUT) begin
                r_pwm[i_cmd.k] <= t2[47:40];
            end
        end
    end

    // Working registers of the PI computation; no reset needed.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: r_item <= i_item;
            DP_ERR:  r_err  <= $signed({r_target[15], r_target})
                             - $signed({r_temp[i_cmd.k][15], r_temp[i_cmd.k]});
            DP_WAIT: begin
                r_eprod <= 34'(r_err * $signed({1'b0, r_period}));
                r_acc   <= sat;
            end
            DP_CLAMP: begin
                if (!kiz) begin
                    r_acc <= cl2;
                end
            end
            DP_MUL1: begin
                r_prop <= 42'(r_err * $signed({1'b0, kp_k}));
                r_plo  <= ki_k * r_acc[23:0];
            end
            DP_MUL2: r_phi <= ki_k * r_acc[47:24];
            DP_SUM1: r_ip  <= kiz ? 60'd0 : ({r_phi[35:0], 24'b0} + {12'b0, r_plo});
            DP_SUM2: r_tot <= $signed({{2{r_prop[41]}}, r_prop, 16'b0}) + $signed(r_ip);
            default: ;
        endcase
    end

    always_comb begin
        o_stat.opcode     = r_item.opcode;
        o_stat.channel    = r_item.channel;
        o_stat.activate   = r_item.activate;
        o_stat.val_hot    = r_item.sample_value >= r_thr;
        o_stat.val_low    = r_item.sample_value <= LOW_TARGET;
        o_stat.target_low = r_target <= LOW_TARGET;
        o_stat.rel_hot    = rel_hot;
        o_stat.estop      = r_estop;
        o_stat.safe       = r_safe;
        o_stat.mask       = r_mask;
        o_stat.div_busy   = div_busy;
        o_stat.pwm_sel    = r_pwm[i_cmd.k];
    end

endmodule

>>> src/mphc_ctrl.sv
module mphc_ctrl import mphc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_CHK, S_ERR, S_WAIT, S_CLAMP, S_MUL1, S_MUL2,
        S_SUM1, S_SUM2, S_OUT, S_EMIT, S_STAT
    } t_state;

    t_state          r_state, n_state;
    logic [CH_W-1:0] r_k, n_k;
    logic [3:0]      r_st, n_st;
    logic            r_ov;
    t_out_item       r_oitem;
    logic            out_free;
    logic            ch_ok, ch_act;
    t_dp_cmd         cmd;

    assign out_free = !r_ov || !i_out_stall;
    assign ch_ok    = !i_stat.channel[3] && (i_stat.channel[CH_W-1:0] < CH_W'(CH_N));
    assign ch_act   = ch_ok && i_stat.mask[i_stat.channel[CH_W-1:0]];

    always_comb begin
        cmd     = '0;
        cmd.op  = DP_NOP;
        cmd.k   = r_k;
        n_state = r_state;
        n_k     = r_k;
        n_st    = r_st;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.op  = DP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_st    = ST_DONE;
                n_state = S_STAT;
                n_k     = '0;
                case (i_stat.opcode)
                    OP_SAMPLE: begin
                        if (!ch_ok) begin
                            n_st = ST_INVALID;
                        end else if (!ch_act) begin
                            n_st = ST_INACTIVE;
                        end else begin
                            cmd.wr_temp = 1'b1;
                            if (i_stat.val_hot && i_stat.safe) begin
                                cmd.clr_safe  = 1'b1;
                                cmd.set_estop = 1'b1;
                                cmd.zero_pwm  = 1'b1;
                                cmd.clr_integ = 1'b1;
                                n_st          = ST_OVERHEAT;
                                n_state       = S_EMIT;
                            end
                        end
                    end
                    OP_TICK: begin
                        if (i_stat.estop || i_stat.target_low) begin
                            cmd.zero_pwm = 1'b1;
                            n_state      = S_EMIT;
                        end else begin
                            n_state = S_CHK;
                        end
                    end
                    OP_TARGET: begin
                        if (i_stat.estop) begin
                            n_st = ST_TARGET_IGN;
                        end else begin
                            cmd.wr_target = 1'b1;
                            if (i_stat.val_low) begin
                                cmd.zero_pwm = 1'b1;
                                n_st         = ST_ZERO_TARGET;
                                n_state      = S_EMIT;
                            end else begin
                                cmd.clr_integ = 1'b1;
                            end
                        end
                    end
                    OP_ESTOP: begin
                        if (i_stat.activate) begin
                            if (!i_stat.estop) begin
                                cmd.set_estop = 1'b1;
                                cmd.zero_pwm  = 1'b1;
                                cmd.clr_integ = 1'b1;
                                n_st          = ST_STOP_ON;
                                n_state       = S_EMIT;
                            end else begin
                                n_st = ST_STOP_ALRDY;
                            end
                        end else if (i_stat.estop) begin
                            cmd.clr_estop = 1'b1;
                            if (i_stat.rel_hot) begin
                                n_st = ST_STILL_HOT;
                            end else begin
                                cmd.set_safe = 1'b1;
                            end
                        end else begin
                            n_st = ST_ALRDY_REL;
                        end
                    end
                    OP_GAINS: begin
                        if (ch_ok) begin
                            if (ch_act) begin
                                cmd.gain_one = 1'b1;
                            end else begin
                                n_st = ST_INACTIVE;
                            end
                        end else if (i_stat.channel == -4'sd1) begin
                            cmd.gain_all = 1'b1;
                        end else begin
                            n_st = ST_INVALID;
                        end
                    end
                    default: n_st = ST_INVALID;
                endcase
            end
            S_CHK: begin
                if (i_stat.mask[r_k]) begin
                    n_state = S_ERR;
                end else if (r_k == CH_W'(CH_N - 1)) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_ERR: begin
                cmd.op  = DP_ERR;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                cmd.op = DP_WAIT;
                if (!i_stat.div_busy) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                cmd.op  = DP_CLAMP;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                cmd.op  = DP_MUL1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                cmd.op  = DP_MUL2;
                n_state = S_SUM1;
            end
            S_SUM1: begin
                cmd.op  = DP_SUM1;
                n_state = S_SUM2;
            end
            S_SUM2: begin
                cmd.op  = DP_SUM2;
                n_state = S_OUT;
            end
            S_OUT: begin
                cmd.op = DP_OUT;
                if (r_k == CH_W'(CH_N - 1)) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_CHK;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    if (r_k == CH_W'(CH_N - 1)) begin
                        n_k     = '0;
                        n_state = S_STAT;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_st    <= ST_DONE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_st    <= n_st;
            if (r_state == S_EMIT && out_free) begin
                r_ov                <= 1'b1;
                r_oitem.status      <= ST_PWM;
                r_oitem.out_channel <= r_k;
                r_oitem.pwm         <= i_stat.pwm_sel;
                r_oitem.emergency   <= i_stat.estop;
                r_oitem.last        <= 1'b0;
            end else if (r_state == S_STAT && out_free) begin
                r_ov                <= 1'b1;
                r_oitem.status      <= r_st;
                r_oitem.out_channel <= '0;
                r_oitem.pwm         <= '0;
                r_oitem.emergency   <= i_stat.estop;
                r_oitem.last        <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_item  = r_oitem;

endmodule
